// ===== rtl/sbfi_pkg.sv =====
package sbfi_pkg;

   localparam int NUM_FACES = 6;
   localparam int DIV_STAGES = 17;
   localparam int FACE_LATENCY = 3 + DIV_STAGES;
   localparam logic [30:0] HALF_RESET = 31'd65536;

   typedef enum logic [1:0] {
      CSR_HALF_X = 2'd0,
      CSR_HALF_Y = 2'd1,
      CSR_HALF_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic signed [31:0] prior_t;
   } req_type;

   typedef struct packed {
      logic               any_hit;
      logic               improved;
      logic [2:0]         face;
      logic signed [31:0] hit_t;
      logic [16:0]        hit_u;
      logic [16:0]        hit_v;
   } rsp_type;

   typedef struct packed {
      logic [2:0] corner_pos;
      logic [1:0] na;
      logic [1:0] ua;
      logic       u_neg;
      logic [1:0] va;
      logic       v_neg;
   } face_desc_type;

   localparam face_desc_type FACES [NUM_FACES] = '{
      '{corner_pos: 3'b110, na: 2'd1, ua: 2'd0, u_neg: 1'b0, va: 2'd2, v_neg: 1'b1},
      '{corner_pos: 3'b100, na: 2'd2, ua: 2'd0, u_neg: 1'b0, va: 2'd1, v_neg: 1'b0},
      '{corner_pos: 3'b101, na: 2'd0, ua: 2'd2, u_neg: 1'b1, va: 2'd1, v_neg: 1'b0},
      '{corner_pos: 3'b001, na: 2'd2, ua: 2'd0, u_neg: 1'b1, va: 2'd1, v_neg: 1'b0},
      '{corner_pos: 3'b000, na: 2'd0, ua: 2'd2, u_neg: 1'b0, va: 2'd1, v_neg: 1'b0},
      '{corner_pos: 3'b000, na: 2'd1, ua: 2'd0, u_neg: 1'b0, va: 2'd2, v_neg: 1'b0}
   };

endpackage

// ===== rtl/sbfi_div.sv =====
module sbfi_div (
   input  logic        clock,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [16:0] quo
);
   import sbfi_pkg::*;

   logic [63:0] rem_ff [DIV_STAGES];
   logic [63:0] den_ff [DIV_STAGES];
   logic [16:0] quo_ff [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
      logic [64:0] rin;
      logic [63:0] din;
      logic [16:0] qin;
      logic        ge;
      logic [64:0] diff;

      if (j == 0) begin : g_first
         assign rin = {1'b0, num};
         assign din = den;
         assign qin = '0;
      end else begin : g_next
         assign rin = {rem_ff[j-1], 1'b0};
         assign din = den_ff[j-1];
         assign qin = quo_ff[j-1];
      end

      assign ge   = rin >= {1'b0, din};
      assign diff = rin - {1'b0, din};

      always_ff @(posedge clock) begin
         rem_ff[j] <= ge ? diff[63:0] : rin[63:0];
         den_ff[j] <= din;
         quo_ff[j] <= {qin[15:0], ge};
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];
endmodule

// ===== rtl/sbfi_face.sv =====
module sbfi_face (
   input  logic                    clock,
   input  sbfi_pkg::face_desc_type desc,
   input  logic [2:0][31:0]        p1,
   input  logic [2:0][31:0]        p2,
   input  logic [2:0][30:0]        half,
   output logic                    hit,
   output logic [16:0]             tq,
   output logic [16:0]             uq,
   output logic [16:0]             vq
);
   import sbfi_pkg::*;

   logic signed [32:0] a [3];
   logic signed [33:0] d [3];
   logic signed [32:0] ak;
   logic signed [32:0] ak_neg;
   logic signed [33:0] dk;

   always_comb begin
      for (int m = 0; m < 3; m++) begin
         a[m] = $signed({p1[m][31], p1[m]}) - $signed({p2[m][31], p2[m]});
         if (desc.corner_pos[m]) begin
            d[m] = $signed({{2{p1[m][31]}}, p1[m]}) - $signed({3'b000, half[m]});
         end else begin
            d[m] = $signed({{2{p1[m][31]}}, p1[m]}) + $signed({3'b000, half[m]});
         end
      end
      ak     = a[desc.na];
      ak_neg = -ak;
      dk     = ak[32] ? -d[desc.na] : d[desc.na];
   end

   logic [31:0]        s1_a_ff;
   logic signed [33:0] s1_dk_ff;
   logic signed [33:0] s1_du_ff;
   logic signed [33:0] s1_dv_ff;
   logic signed [32:0] s1_au_ff;
   logic signed [32:0] s1_av_ff;
   logic [30:0]        s1_hu_ff;
   logic [30:0]        s1_hv_ff;
   logic               s1_zero_ff;

   always_ff @(posedge clock) begin
      s1_a_ff    <= ak[32] ? ak_neg[31:0] : ak[31:0];
      s1_dk_ff   <= dk;
      s1_du_ff   <= d[desc.ua];
      s1_dv_ff   <= d[desc.va];
      s1_au_ff   <= a[desc.ua];
      s1_av_ff   <= a[desc.va];
      s1_hu_ff   <= half[desc.ua];
      s1_hv_ff   <= half[desc.va];
      s1_zero_ff <= (ak == '0) || (half[desc.ua] == '0) || (half[desc.va] == '0);
   end

   logic signed [32:0] a_s;
   logic signed [66:0] pu_in;
   logic signed [66:0] qu_in;
   logic signed [66:0] pv_in;
   logic signed [66:0] qv_in;

   assign a_s   = $signed({1'b0, s1_a_ff});
   assign pu_in = s1_du_ff * a_s;
   assign qu_in = s1_dk_ff * s1_au_ff;
   assign pv_in = s1_dv_ff * a_s;
   assign qv_in = s1_dk_ff * s1_av_ff;

   logic signed [66:0] s2_pu_ff;
   logic signed [66:0] s2_qu_ff;
   logic signed [66:0] s2_pv_ff;
   logic signed [66:0] s2_qv_ff;
   logic [63:0]        s2_denu_ff;
   logic [63:0]        s2_denv_ff;
   logic [31:0]        s2_a_ff;
   logic [31:0]        s2_dk_ff;
   logic               s2_ok_ff;

   always_ff @(posedge clock) begin
      s2_pu_ff   <= pu_in;
      s2_qu_ff   <= qu_in;
      s2_pv_ff   <= pv_in;
      s2_qv_ff   <= qv_in;
      s2_denu_ff <= {s1_hu_ff, 1'b0} * s1_a_ff;
      s2_denv_ff <= {s1_hv_ff, 1'b0} * s1_a_ff;
      s2_a_ff    <= s1_a_ff;
      s2_dk_ff   <= s1_dk_ff[31:0];
      s2_ok_ff   <= !s1_zero_ff && !s1_dk_ff[33] && (s1_dk_ff <= $signed({2'b00, s1_a_ff}));
   end

   logic signed [68:0] diff_u;
   logic signed [68:0] diff_v;
   logic signed [68:0] num_u;
   logic signed [68:0] num_v;
   logic               ok_u;
   logic               ok_v;

   always_comb begin
      diff_u = $signed({{2{s2_pu_ff[66]}}, s2_pu_ff}) - $signed({{2{s2_qu_ff[66]}}, s2_qu_ff});
      diff_v = $signed({{2{s2_pv_ff[66]}}, s2_pv_ff}) - $signed({{2{s2_qv_ff[66]}}, s2_qv_ff});
      num_u  = desc.u_neg ? -diff_u : diff_u;
      num_v  = desc.v_neg ? -diff_v : diff_v;
      ok_u   = !num_u[68] && (num_u <= $signed({5'b00000, s2_denu_ff}));
      ok_v   = !num_v[68] && (num_v <= $signed({5'b00000, s2_denv_ff}));
   end

   logic [63:0] s3_numu_ff;
   logic [63:0] s3_numv_ff;
   logic [63:0] s3_denu_ff;
   logic [63:0] s3_denv_ff;
   logic [31:0] s3_a_ff;
   logic [31:0] s3_dk_ff;
   logic        s3_hit_ff;

   always_ff @(posedge clock) begin
      s3_numu_ff <= num_u[63:0];
      s3_numv_ff <= num_v[63:0];
      s3_denu_ff <= s2_denu_ff;
      s3_denv_ff <= s2_denv_ff;
      s3_a_ff    <= s2_a_ff;
      s3_dk_ff   <= s2_dk_ff;
      s3_hit_ff  <= s2_ok_ff && ok_u && ok_v;
   end

   sbfi_div u_div_t (
      .clock (clock),
      .num   ({32'd0, s3_dk_ff}),
      .den   ({32'd0, s3_a_ff}),
      .quo   (tq)
   );

   sbfi_div u_div_u (
      .clock (clock),
      .num   (s3_numu_ff),
      .den   (s3_denu_ff),
      .quo   (uq)
   );

   sbfi_div u_div_v (
      .clock (clock),
      .num   (s3_numv_ff),
      .den   (s3_denv_ff),
      .quo   (vq)
   );

   logic hit_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      hit_ff[0] <= s3_hit_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         hit_ff[i] <= hit_ff[i-1];
      end
   end

   assign hit = hit_ff[DIV_STAGES-1];
endmodule

// ===== rtl/segment_box_face_intersect_unit.sv =====
// Channel  Handshake              Payload
// request  start, busy            req_data  (segment ends and prior t)
// result   rsp_valid strobe       rsp_data  (hit flags, face, t, u, v)
// config   csr_valid, csr_ready   csr_index, csr_data
//
// One transaction enters per cycle; busy is always low and csr_ready always high.
// Each result passes through the face stages, the 17-step divider pipes and an output register.
// Reset clears the valid pipe and sets every half extent to 1.0.
// Nothing stalls: the receiver takes each result in its single strobe cycle.
module segment_box_face_intersect_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sbfi_pkg::req_type req_data,
   output logic              rsp_valid,
   output sbfi_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import sbfi_pkg::*;

   logic [30:0] half_x_ff;
   logic [30:0] half_y_ff;
   logic [30:0] half_z_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_x_ff <= HALF_RESET;
         half_y_ff <= HALF_RESET;
         half_z_ff <= HALF_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_X: half_x_ff <= csr_data[30:0];
            CSR_HALF_Y: half_y_ff <= csr_data[30:0];
            CSR_HALF_Z: half_z_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   logic [2:0][31:0] p1;
   logic [2:0][31:0] p2;
   logic [2:0][30:0] half;

   assign p1   = {req_data.start_z, req_data.start_y, req_data.start_x};
   assign p2   = {req_data.end_z, req_data.end_y, req_data.end_x};
   assign half = {half_z_ff, half_y_ff, half_x_ff};

   logic        hit [NUM_FACES];
   logic [16:0] tq  [NUM_FACES];
   logic [16:0] uq  [NUM_FACES];
   logic [16:0] vq  [NUM_FACES];

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
      sbfi_face u_face (
         .clock (clock),
         .desc  (FACES[f]),
         .p1    (p1),
         .p2    (p2),
         .half  (half),
         .hit   (hit[f]),
         .tq    (tq[f]),
         .uq    (uq[f]),
         .vq    (vq[f])
      );
   end

   logic               valid_ff [FACE_LATENCY];
   logic signed [31:0] prior_ff [FACE_LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FACE_LATENCY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= start && !busy;
         for (int i = 1; i < FACE_LATENCY; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      prior_ff[0] <= req_data.prior_t;
      for (int i = 1; i < FACE_LATENCY; i++) begin
         prior_ff[i] <= prior_ff[i-1];
      end
   end

   rsp_type rsp_in;

   always_comb begin
      rsp_in          = '0;
      rsp_in.hit_t    = prior_ff[FACE_LATENCY-1];
      for (int f = 0; f < NUM_FACES; f++) begin
         if (hit[f]) begin
            rsp_in.any_hit = 1'b1;
            if ($signed({15'd0, tq[f]}) < rsp_in.hit_t) begin
               rsp_in.improved = 1'b1;
               rsp_in.face     = 3'(f);
               rsp_in.hit_t    = {15'd0, tq[f]};
               rsp_in.hit_u    = uq[f];
               rsp_in.hit_v    = vq[f];
            end
         end
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[FACE_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, FACE_LATENCY + 1))
      else $error("Result without a matching request.");

   a_improved_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.improved) |-> rsp_data.any_hit)
      else $error("Improved result without a hit.");

   a_no_improve: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.improved) |->
         (rsp_data.face == 3'd0 && rsp_data.hit_u == 17'd0 && rsp_data.hit_v == 17'd0))
      else $error("Unimproved result carries face data.");

   a_t_below_prior: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.improved) |->
         ($signed(rsp_data.hit_t) < $signed($past(req_data.prior_t, FACE_LATENCY + 1))))
      else $error("Improved t is not below the prior t.");

   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.face <= 3'd5))
      else $error("Face index out of range.");
endmodule
